/* sv/swc_pkg.sv */
`default_nettype none

package swc_pkg;

    // Field and register widths
    localparam int IN_W      = 24;
    localparam int CFG_W     = 23;
    localparam int RATE_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = IN_W + 1;
    localparam int H_W       = IN_W + 2;
    localparam int INNER_W   = 32;
    localparam int FRAC_BITS = 16;

    // Depth divider: quotient of (q2 << FRAC_BITS) / h, one bit per stage
    localparam int DIV_BITS  = INNER_W - 1;
    localparam int DIV_NUM_W = INNER_W - 1;
    localparam int DIV_DEN_W = H_W - 1;
    localparam int DIV_LAT   = DIV_BITS + 1;

    // Accepting edge to result strobe
    localparam int PIPE_LAT  = DIV_LAT + 11;

    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RATE    = 2'd3;

    localparam logic [CFG_W-1:0]  RST_LATTICE_SPEED = 23'd131072;
    localparam logic [CFG_W-1:0]  RST_INVERSE_SPEED = 23'd32768;
    localparam logic [CFG_W-1:0]  RST_GRAVITY       = 23'd65536;
    localparam logic [RATE_W-1:0] RST_RELAX_RATE    = 18'd65536;

    localparam logic signed [INNER_W-1:0] INNER_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [IN_W-1:0]    OUT_MAX   = 24'sh7F_FFFF;
    localparam logic signed [IN_W-1:0]    OUT_MIN   = 24'sh80_0000;

    typedef struct packed {
        logic signed [IN_W-1:0] dist_rest;
        logic signed [IN_W-1:0] dist_right;
        logic signed [IN_W-1:0] dist_left;
    } t_cell_in;

    typedef struct packed {
        logic signed [IN_W-1:0] new_rest;
        logic signed [IN_W-1:0] new_right;
        logic signed [IN_W-1:0] new_left;
        logic                   depth_error;
    } t_cell_out;

    // Clamp to the symmetric internal range
    function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'(INNER_MAX);
        lo = -hi;
        if (x > hi) begin
            sat_inner = INNER_MAX;
        end else if (x < lo) begin
            sat_inner = -INNER_MAX;
        end else begin
            sat_inner = x[INNER_W-1:0];
        end
    endfunction

    // Finish a Q.16 product: floor shift, then clamp
    function automatic logic signed [INNER_W-1:0] mulq_fin(input logic signed [63:0] p);
        mulq_fin = sat_inner(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [IN_W-1:0] sat_out(input logic signed [63:0] x);
        if (x > 64'(OUT_MAX)) begin
            sat_out = OUT_MAX;
        end else if (x < 64'(OUT_MIN)) begin
            sat_out = OUT_MIN;
        end else begin
            sat_out = x[IN_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/swc_div.sv */
`default_nettype none

module swc_div import swc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_valid,
    output logic [DIV_BITS-1:0]       o_quo
);

    localparam int LOW_W = DIV_BITS;

    logic                 r_v   [0:DIV_BITS];
    logic                 r_sat [0:DIV_BITS];
    logic [DIV_DEN_W-1:0] r_rem [0:DIV_BITS];
    logic [DIV_DEN_W-1:0] r_den [0:DIV_BITS];
    logic [LOW_W-1:0]     r_low [0:DIV_BITS];
    logic [DIV_BITS-1:0]  r_quo [0:DIV_BITS];

    // Entry: the top dividend bits stay below the divisor unless the quotient overflows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat[0] <= (DIV_DEN_W + DIV_BITS - FRAC_BITS)'(i_num)
                    >= {i_den, (DIV_BITS - FRAC_BITS)'(0)};
        r_rem[0] <= DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_BITS-FRAC_BITS]);
        r_low[0] <= {i_num[DIV_BITS-FRAC_BITS-1:0], FRAC_BITS'(0)};
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
        logic [DIV_DEN_W:0] w_trial;
        logic [DIV_DEN_W:0] w_diff;
        logic               w_ge;

        always_comb begin
            w_trial = {r_rem[k], r_low[k][LOW_W-1]};
            w_diff  = w_trial - {1'b0, r_den[k]};
            w_ge    = w_trial >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sat[k+1] <= r_sat[k];
            r_den[k+1] <= r_den[k];
            r_rem[k+1] <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_low[k+1] <= {r_low[k][LOW_W-2:0], 1'b0};
            r_quo[k+1] <= {r_quo[k][DIV_BITS-2:0], w_ge};
        end
    end

    assign o_valid = r_v[DIV_BITS];
    assign o_quo   = r_sat[DIV_BITS] ? '1 : r_quo[DIV_BITS];

endmodule

`default_nettype wire

/* sv/d1q3_shallow_water_collision_unit.sv */
`default_nettype none

// D1Q3 shallow-water collision, one lattice cell per transaction.
// Input channel: raise start with the cell's three distributions on i_cell;
// the transaction is taken at the edge where start is high and busy is low.
// busy never rises, so a new cell may be offered on every cycle.
// Result channel: o_done is high for exactly one cycle with the new
// distributions and the depth error flag on o_res. The receiver cannot hold
// results off, and none is needed: every stage advances on every cycle.
// The depth divider retires one quotient bit per stage. Throughput is one
// cell per cycle.
// Configuration: i_cfg_we, i_cfg_idx and i_cfg_data write lattice speed,
// inverse speed, gravity and relaxation rate; write them only while no cell
// is in flight.
// Reset (synchronous, active low) returns the registers to their defaults
// and drops every cell in flight; no result is given for those cells.
module d1q3_shallow_water_collision_unit import swc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_cell_in             i_cell,
    output logic                      o_done,
    output t_cell_out                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    typedef struct packed {
        logic                      err;
        logic signed [H_W-1:0]     h;
        logic signed [INNER_W-1:0] q;
        logic signed [INNER_W-1:0] kin;
        logic signed [INNER_W-1:0] pot;
    } t_side;

    // Configuration registers
    logic [CFG_W-1:0]  r_lam;
    logic [CFG_W-1:0]  r_inv;
    logic [CFG_W-1:0]  r_g;
    logic [RATE_W-1:0] r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam <= RST_LATTICE_SPEED;
            r_inv <= RST_INVERSE_SPEED;
            r_g   <= RST_GRAVITY;
            r_s   <= RST_RELAX_RATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LATTICE_SPEED: r_lam <= i_cfg_data;
                CFG_INVERSE_SPEED: r_inv <= i_cfg_data;
                CFG_GRAVITY:       r_g   <= i_cfg_data;
                CFG_RELAX_RATE:    r_s   <= i_cfg_data[RATE_W-1:0];
            endcase
        end
    end

    logic signed [CFG_W:0]  w_lam;
    logic signed [CFG_W:0]  w_inv;
    logic signed [CFG_W:0]  w_g;
    logic signed [RATE_W:0] w_s;

    assign w_lam = $signed({1'b0, r_lam});
    assign w_inv = $signed({1'b0, r_inv});
    assign w_g   = $signed({1'b0, r_g});
    assign w_s   = $signed({1'b0, r_s});

    assign busy = 1'b0;

    logic w_acc;
    assign w_acc = start && !busy;

    // Stage 1: depth and the sum and difference of the moving populations
    logic signed [H_W-1:0]   w_h;
    logic signed [SUM_W-1:0] w_d;
    logic signed [SUM_W-1:0] w_sm;
    logic                    w_err;

    always_comb begin
        w_h   = H_W'(i_cell.dist_rest) + H_W'(i_cell.dist_right) + H_W'(i_cell.dist_left);
        w_d   = SUM_W'(i_cell.dist_right) - SUM_W'(i_cell.dist_left);
        w_sm  = SUM_W'(i_cell.dist_right) + SUM_W'(i_cell.dist_left);
        w_err = w_h <= 0;
    end

    logic                    r_1_v;
    logic                    r_1_err;
    logic signed [H_W-1:0]   r_1_h;
    logic signed [SUM_W-1:0] r_1_d;
    logic signed [SUM_W-1:0] r_1_sm;

    always_ff @(posedge i_clk) begin
        r_1_err <= w_err;
        r_1_h   <= w_h;
        r_1_d   <= w_d;
        r_1_sm  <= w_sm;
    end

    // Stage A: momentum, lambda squared, depth squared
    logic signed [CFG_W+SUM_W:0] p_q;
    logic signed [2*CFG_W+1:0]   p_l2;
    logic signed [2*H_W-1:0]     p_hh;

    assign p_q  = w_lam * r_1_d;
    assign p_l2 = w_lam * w_lam;
    assign p_hh = r_1_h * r_1_h;

    logic                      r_a_v;
    logic                      r_a_err;
    logic signed [H_W-1:0]     r_a_h;
    logic signed [SUM_W-1:0]   r_a_sm;
    logic signed [INNER_W-1:0] r_a_q;
    logic signed [INNER_W-1:0] r_a_l2;
    logic signed [INNER_W-1:0] r_a_hh;

    always_ff @(posedge i_clk) begin
        r_a_err <= r_1_err;
        r_a_h   <= r_1_h;
        r_a_sm  <= r_1_sm;
        r_a_q   <= mulq_fin(64'(p_q));
        r_a_l2  <= mulq_fin(64'(p_l2));
        r_a_hh  <= mulq_fin(64'(p_hh));
    end

    // Stage B: q squared, second moment, g times h squared
    logic signed [2*INNER_W-1:0]     p_qq;
    logic signed [INNER_W+SUM_W-1:0] p_kin;
    logic signed [INNER_W+CFG_W:0]   p_ghh;

    assign p_qq  = r_a_q * r_a_q;
    assign p_kin = r_a_l2 * r_a_sm;
    assign p_ghh = w_g * r_a_hh;

    logic                      r_b_v;
    logic                      r_b_err;
    logic signed [H_W-1:0]     r_b_h;
    logic signed [INNER_W-1:0] r_b_q;
    logic signed [INNER_W-1:0] r_b_q2;
    logic signed [INNER_W-1:0] r_b_kin;
    logic signed [INNER_W-1:0] r_b_ghh;

    always_ff @(posedge i_clk) begin
        r_b_err <= r_a_err;
        r_b_h   <= r_a_h;
        r_b_q   <= r_a_q;
        r_b_q2  <= mulq_fin(64'(p_qq));
        r_b_kin <= mulq_fin(64'(p_kin));
        r_b_ghh <= mulq_fin(64'(p_ghh));
    end

    // q^2/h in the divider; the rest of the cell travels alongside
    logic                div_v;
    logic [DIV_BITS-1:0] div_quo;

    swc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_v),
        .i_num   (r_b_q2[DIV_NUM_W-1:0]),
        .i_den   (r_b_h[DIV_DEN_W-1:0]),
        .o_valid (div_v),
        .o_quo   (div_quo)
    );

    t_side r_side [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        r_side[0].err <= r_b_err;
        r_side[0].h   <= r_b_h;
        r_side[0].q   <= r_b_q;
        r_side[0].kin <= r_b_kin;
        r_side[0].pot <= r_b_ghh >>> 1;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    t_side w_sd;
    assign w_sd = r_side[DIV_LAT-1];

    // Stage D: equilibrium second moment
    logic signed [INNER_W:0] w_keq_sum;
    assign w_keq_sum = (INNER_W+1)'($signed({1'b0, div_quo})) + (INNER_W+1)'(w_sd.pot);

    logic                      r_d_v;
    logic                      r_d_err;
    logic signed [H_W-1:0]     r_d_h;
    logic signed [INNER_W-1:0] r_d_q;
    logic signed [INNER_W-1:0] r_d_kin;
    logic signed [INNER_W-1:0] r_d_keq;

    always_ff @(posedge i_clk) begin
        r_d_err <= w_sd.err;
        r_d_h   <= w_sd.h;
        r_d_q   <= w_sd.q;
        r_d_kin <= w_sd.kin;
        r_d_keq <= sat_inner(64'(w_keq_sum));
    end

    // Stage E: distance to equilibrium, left unclamped
    logic                      r_e_v;
    logic                      r_e_err;
    logic signed [H_W-1:0]     r_e_h;
    logic signed [INNER_W-1:0] r_e_q;
    logic signed [INNER_W-1:0] r_e_kin;
    logic signed [INNER_W:0]   r_e_diff;

    always_ff @(posedge i_clk) begin
        r_e_err  <= r_d_err;
        r_e_h    <= r_d_h;
        r_e_q    <= r_d_q;
        r_e_kin  <= r_d_kin;
        r_e_diff <= (INNER_W+1)'(r_d_keq) - (INNER_W+1)'(r_d_kin);
    end

    // Stage F: scale by the relaxation rate
    logic signed [INNER_W+RATE_W+1:0] p_t;
    assign p_t = w_s * r_e_diff;

    logic                      r_f_v;
    logic                      r_f_err;
    logic signed [H_W-1:0]     r_f_h;
    logic signed [INNER_W-1:0] r_f_q;
    logic signed [INNER_W-1:0] r_f_kin;
    logic signed [INNER_W-1:0] r_f_t;

    always_ff @(posedge i_clk) begin
        r_f_err <= r_e_err;
        r_f_h   <= r_e_h;
        r_f_q   <= r_e_q;
        r_f_kin <= r_e_kin;
        r_f_t   <= mulq_fin(64'(p_t));
    end

    // Stage G: relaxed second moment
    logic signed [INNER_W:0] w_kc_sum;
    assign w_kc_sum = (INNER_W+1)'(r_f_kin) + (INNER_W+1)'(r_f_t);

    logic                      r_g_v;
    logic                      r_g_err;
    logic signed [H_W-1:0]     r_g_h;
    logic signed [INNER_W-1:0] r_g_q;
    logic signed [INNER_W-1:0] r_g_kc;

    always_ff @(posedge i_clk) begin
        r_g_err <= r_f_err;
        r_g_h   <= r_f_h;
        r_g_q   <= r_f_q;
        r_g_kc  <= sat_inner(64'(w_kc_sum));
    end

    // Stage H: k / lambda
    logic signed [INNER_W+CFG_W:0] p_kl;
    assign p_kl = r_g_kc * w_inv;

    logic                      r_h_v;
    logic                      r_h_err;
    logic signed [H_W-1:0]     r_h_h;
    logic signed [INNER_W-1:0] r_h_q;
    logic signed [INNER_W-1:0] r_h_kl;

    always_ff @(posedge i_clk) begin
        r_h_err <= r_g_err;
        r_h_h   <= r_g_h;
        r_h_q   <= r_g_q;
        r_h_kl  <= mulq_fin(64'(p_kl));
    end

    // Stage I: k / lambda^2 and the two flux sums
    logic signed [INNER_W+CFG_W:0] p_kll;
    assign p_kll = r_h_kl * w_inv;

    logic                      r_i_v;
    logic                      r_i_err;
    logic signed [H_W-1:0]     r_i_h;
    logic signed [INNER_W-1:0] r_i_kll;
    logic signed [INNER_W:0]   r_i_a;
    logic signed [INNER_W:0]   r_i_b;

    always_ff @(posedge i_clk) begin
        r_i_err <= r_h_err;
        r_i_h   <= r_h_h;
        r_i_kll <= mulq_fin(64'(p_kll));
        r_i_a   <= (INNER_W+1)'(r_h_q) + (INNER_W+1)'(r_h_kl);
        r_i_b   <= (INNER_W+1)'(r_h_kl) - (INNER_W+1)'(r_h_q);
    end

    // Stage J: rest population and the scaled moving ones
    logic signed [INNER_W:0]         w_r0;
    logic signed [INNER_W+CFG_W+1:0] p_m1;
    logic signed [INNER_W+CFG_W+1:0] p_m2;

    assign w_r0 = (INNER_W+1)'(r_i_h) - (INNER_W+1)'(r_i_kll);
    assign p_m1 = r_i_a * w_inv;
    assign p_m2 = r_i_b * w_inv;

    logic                      r_j_v;
    logic                      r_j_err;
    logic signed [IN_W-1:0]    r_j_r0;
    logic signed [INNER_W-1:0] r_j_m1;
    logic signed [INNER_W-1:0] r_j_m2;

    always_ff @(posedge i_clk) begin
        r_j_err <= r_i_err;
        r_j_r0  <= sat_out(64'(w_r0));
        r_j_m1  <= mulq_fin(64'(p_m1));
        r_j_m2  <= mulq_fin(64'(p_m2));
    end

    // Stage K: halve, clamp, zero on a dry cell
    t_cell_out r_res;
    logic      r_done;

    always_ff @(posedge i_clk) begin
        if (r_j_err) begin
            r_res <= '{new_rest: '0, new_right: '0, new_left: '0, depth_error: 1'b1};
        end else begin
            r_res.new_rest    <= r_j_r0;
            r_res.new_right   <= sat_out(64'(r_j_m1 >>> 1));
            r_res.new_left    <= sat_out(64'(r_j_m2 >>> 1));
            r_res.depth_error <= 1'b0;
        end
    end

    // Valid bits advance every cycle; reset drops every transaction in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_v  <= 1'b0;
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_d_v  <= 1'b0;
            r_e_v  <= 1'b0;
            r_f_v  <= 1'b0;
            r_g_v  <= 1'b0;
            r_h_v  <= 1'b0;
            r_i_v  <= 1'b0;
            r_j_v  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_1_v  <= w_acc;
            r_a_v  <= r_1_v;
            r_b_v  <= r_a_v;
            r_d_v  <= div_v;
            r_e_v  <= r_d_v;
            r_f_v  <= r_e_v;
            r_g_v  <= r_f_v;
            r_h_v  <= r_g_v;
            r_i_v  <= r_h_v;
            r_j_v  <= r_i_v;
            r_done <= r_j_v;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_dry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.depth_error |->
            o_res.new_rest == '0 && o_res.new_right == '0 && o_res.new_left == '0)
        else $error("dry cell gave non-zero distributions");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, PIPE_LAT))
        else $error("result without a transaction accepted at the pipeline latency");

    a_err_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_res.depth_error == $past(w_err, PIPE_LAT))
        else $error("depth error flag out of step with its transaction");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;
    import swc_pkg::*;

    localparam int     WATCHDOG_LIMIT = 1000;
    localparam longint INNER_LIM      = 64'sd2147483647;
    localparam longint DIST_MAX       = 64'sd8388607;
    localparam longint DIST_MIN       = -64'sd8388608;
    localparam logic [CFG_W-1:0] REG_ONES = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cell_in             i_cell;
    logic                 o_done;
    t_cell_out            o_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    // Register copies used by the collision predictor
    logic [CFG_W-1:0]  cfg_lambda;
    logic [CFG_W-1:0]  cfg_inv_lambda;
    logic [CFG_W-1:0]  cfg_gravity;
    logic [RATE_W-1:0] cfg_relax;

    t_cell_out pending_collisions[$];
    int        n_fail;
    int        idle_cycles;
    bit        idle_on;

    d1q3_shallow_water_collision_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cell     (i_cell),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip_inner(input longint x);
        if (x > INNER_LIM) return INNER_LIM;
        if (x < -INNER_LIM) return -INNER_LIM;
        return x;
    endfunction

    function automatic longint clip_dist(input longint x);
        if (x > DIST_MAX) return DIST_MAX;
        if (x < DIST_MIN) return DIST_MIN;
        return x;
    endfunction

    // Q.16 product, floored, then clamped to the inner range
    function automatic longint qmul(input longint a, input longint b);
        return clip_inner((a * b) >>> FRAC_BITS);
    endfunction

    function automatic t_cell_out collide_cell(input t_cell_in c);
        longint f0, f1, f2, h, lam, inv, g, s;
        longint q, lam2, kin, q2, q2h, hh, pot, keq, kc, kl, kll;
        longint r0, r1, r2;
        t_cell_out r;
        f0  = longint'(c.dist_rest);
        f1  = longint'(c.dist_right);
        f2  = longint'(c.dist_left);
        lam = longint'(cfg_lambda);
        inv = longint'(cfg_inv_lambda);
        g   = longint'(cfg_gravity);
        s   = longint'(cfg_relax);
        r   = '0;
        h   = f0 + f1 + f2;
        if (h <= 0) begin
            r.depth_error = 1'b1;
            return r;
        end
        q    = qmul(lam, f1 - f2);
        lam2 = qmul(lam, lam);
        kin  = qmul(lam2, f1 + f2);
        q2   = qmul(q, q);
        q2h  = clip_inner((q2 <<< FRAC_BITS) / h);
        hh   = qmul(h, h);
        pot  = qmul(g, hh) >>> 1;
        keq  = clip_inner(q2h + pot);
        kc   = clip_inner(kin + qmul(s, keq - kin));
        kl   = qmul(kc, inv);
        kll  = qmul(kl, inv);
        r0   = clip_dist(h - kll);
        r1   = clip_dist(qmul(q + kl, inv) >>> 1);
        r2   = clip_dist(qmul(kl - q, inv) >>> 1);
        r.new_rest  = r0[IN_W-1:0];
        r.new_right = r1[IN_W-1:0];
        r.new_left  = r2[IN_W-1:0];
        return r;
    endfunction

    function automatic t_cell_in make_cell(input logic [IN_W-1:0] a,
                                           input logic [IN_W-1:0] b,
                                           input logic [IN_W-1:0] c);
        t_cell_in item;
        item.dist_rest  = a;
        item.dist_right = b;
        item.dist_left  = c;
        return item;
    endfunction

    // Mostly physical cells (non-negative, shared scale), some signed noise, some raw bits
    function automatic t_cell_in random_cell();
        int kind;
        int k;
        logic [IN_W-1:0] v[3];
        kind = $urandom_range(0, 9);
        k    = $urandom_range(2, 22);
        for (int i = 0; i < 3; i++) begin
            if (kind < 6) begin
                v[i] = IN_W'($urandom_range(0, (1 << k) - 1));
            end else if (kind < 8) begin
                v[i] = IN_W'(int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k));
            end else begin
                v[i] = IN_W'($urandom);
            end
        end
        return make_cell(v[0], v[1], v[2]);
    endfunction

    // Transaction monitor: record predictions on accept, check each strobed result
    always @(posedge i_clk) begin
        t_cell_out want;
        bit        active;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            active = 1'b0;
            if (i_rst_n && start && !busy) begin
                pending_collisions.push_back(collide_cell(i_cell));
                active = 1'b1;
            end
            if (i_rst_n && o_done) begin
                active = 1'b1;
                if (pending_collisions.size() == 0) begin
                    $error("result with no cell in flight");
                    n_fail++;
                end else begin
                    want = pending_collisions.pop_front();
                    if (o_res.new_rest !== want.new_rest) begin
                        $error("new_rest: expected %0d, got %0d",
                               want.new_rest, o_res.new_rest);
                        n_fail++;
                    end
                    if (o_res.new_right !== want.new_right) begin
                        $error("new_right: expected %0d, got %0d",
                               want.new_right, o_res.new_right);
                        n_fail++;
                    end
                    if (o_res.new_left !== want.new_left) begin
                        $error("new_left: expected %0d, got %0d",
                               want.new_left, o_res.new_left);
                        n_fail++;
                    end
                    if (o_res.depth_error !== want.depth_error) begin
                        $error("depth_error: expected %0d, got %0d",
                               want.depth_error, o_res.depth_error);
                        n_fail++;
                    end
                end
            end
            idle_cycles = active ? 0 : idle_cycles + 1;
        end
    end

    task automatic send_cell(input t_cell_in c);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_cell <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and hold until every cell in flight has returned
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_collisions.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LATTICE_SPEED: cfg_lambda     = val;
            CFG_INVERSE_SPEED: cfg_inv_lambda = val;
            CFG_GRAVITY:       cfg_gravity    = val;
            CFG_RELAX_RATE:    cfg_relax      = val[RATE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [CFG_W-1:0] lam, input logic [CFG_W-1:0] inv,
                                  input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] s);
        write_reg(CFG_LATTICE_SPEED, lam);
        write_reg(CFG_INVERSE_SPEED, inv);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_RELAX_RATE, s);
    endtask

    task automatic randomise_regs();
        logic [CFG_W-1:0] lam, inv, g, s;
        longint ratio;
        lam = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(1, 23'h7FFFFF))
                                          : CFG_W'($urandom_range(16384, 524288));
        ratio = (longint'(1) <<< 32) / longint'(lam);
        if (ratio > 64'sh7FFFFF) ratio = 64'sh7FFFFF;
        if (ratio < 1) ratio = 1;
        inv = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(1, 23'h7FFFFF))
                                          : ratio[CFG_W-1:0];
        g   = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 23'h7FFFFF))
                                          : CFG_W'($urandom_range(0, 262144));
        s   = CFG_W'($urandom_range(0, 131072));
        write_all_regs(lam, inv, g, s);
    endtask

    // Depth sign, zero depth, saturation and bit patterns at the reset settings
    task automatic test_depth_cases();
        idle_on = 1'b1;
        send_cell(make_cell(24'd0, 24'd0, 24'd0));
        send_cell(make_cell(24'd1, -24'sd1, 24'd0));
        send_cell(make_cell(24'd0, 24'd0, 24'd1));
        send_cell(make_cell(-24'sd1, 24'd0, 24'd2));
        send_cell(make_cell(OUT_MAX, OUT_MAX, OUT_MAX));
        send_cell(make_cell(OUT_MIN, OUT_MIN, OUT_MIN));
        send_cell(make_cell(24'd0, OUT_MAX, OUT_MIN));
        send_cell(make_cell(24'd1, OUT_MAX, OUT_MIN));
        send_cell(make_cell(24'd2, OUT_MAX, OUT_MIN));
        send_cell(make_cell(24'd2, OUT_MIN, OUT_MAX));
        send_cell(make_cell(OUT_MAX, 24'd0, 24'd0));
        send_cell(make_cell(24'd0, OUT_MAX, 24'd0));
        send_cell(make_cell(24'd0, 24'd0, OUT_MAX));
        send_cell(make_cell(OUT_MIN, OUT_MAX, OUT_MAX));
        send_cell(make_cell(24'd65536, 24'd65536, 24'd65536));
        send_cell(make_cell(24'd65536, 24'd98304, 24'd32768));
        send_cell(make_cell(24'h555555, 24'h555555, 24'hAAAAAA));
        send_cell(make_cell(24'hAAAAAA, 24'h555555, 24'h555555));
        send_cell(make_cell(24'h555555, 24'hAAAAAA, 24'h555555));
        drain();
    endtask

    task automatic test_register_extremes();
        logic [CFG_W-1:0] settings[5][4];
        settings[0] = '{23'd1, REG_ONES, 23'd0, 23'd0};
        // relaxation data above its width is masked off by the block
        settings[1] = '{REG_ONES, 23'd1, REG_ONES, REG_ONES};
        settings[2] = '{23'd65536, 23'd65536, 23'd65536, 23'd131072};
        settings[3] = '{REG_ONES, REG_ONES, REG_ONES, 23'd131072};
        settings[4] = '{23'd1, 23'd1, 23'd0, 23'd65536};
        for (int i = 0; i < 5; i++) begin
            write_all_regs(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
            idle_on = (i % 2 == 0);
            send_cell(make_cell(OUT_MAX, OUT_MAX, OUT_MAX));
            send_cell(make_cell(24'd0, 24'd0, 24'd1));
            for (int n = 0; n < 30; n++) send_cell(random_cell());
            drain();
        end
    endtask

    task automatic test_random_cells();
        for (int phase = 0; phase < 8; phase++) begin
            randomise_regs();
            for (int n = 0; n < 250; n++) begin
                if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
                send_cell(random_cell());
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cell      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_LATTICE_SPEED;
        i_cfg_data  = '0;
        n_fail      = 0;
        idle_cycles = 0;
        idle_on     = 1'b0;
        cfg_lambda     = RST_LATTICE_SPEED;
        cfg_inv_lambda = RST_INVERSE_SPEED;
        cfg_gravity    = RST_GRAVITY;
        cfg_relax      = RST_RELAX_RATE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_depth_cases();
        test_register_extremes();
        test_random_cells();

        // catch any stray strobe after the last expected result
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
